>>> hdl/vpp_pkg.sv
// Shared types, sizes and register indexes of the vertex perspective plotter.
package vpp_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int ADDR_W        = 19;
  localparam int COLOR_W       = 32;
  localparam int WORD_W        = 32;

  localparam int MAX_DIM = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  // Signed width of a screen dimension used as a multiplier.
  localparam int DIM_W   = $clog2(MAX_DIM + 1) + 1;
  // Quotient bits: a column or row below MAX_DIM.
  localparam int QW      = $clog2(MAX_DIM);
  localparam int PROD_W  = 64 + DIM_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int PIX_W   = QW + DIM_W;

  localparam int MID_DEPTH = 8;
  localparam int MID_AW    = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH = 32;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_XY    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH_A     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH_B     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_NEAR_PLANE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_X    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Z    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_COLOR = 3'd7;

  localparam logic [WORD_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
  } vertex_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] plot_color;
  } result_t;

  typedef struct packed {
    logic signed [31:0]  scale_xy;
    logic signed [31:0]  depth_a;
    logic signed [31:0]  depth_b;
    logic signed [31:0]  near_plane;
    logic signed [31:0]  offset_x;
    logic signed [31:0]  offset_y;
    logic signed [31:0]  offset_z;
    logic [COLOR_W-1:0]  pixel_color;
  } cfg_t;

  typedef struct packed {
    logic signed [63:0] xp;
    logic signed [63:0] yp;
    logic signed [63:0] zp;
  } mid_item_t;

endpackage

>>> hdl/vpp_front.sv
// Front end: offset, perspective products and clip test, with queue credit.
module vpp_front (
  input  logic                clk,
  input  logic                rst,
  input  vpp_pkg::cfg_t       cfg,
  input  logic                push,
  output logic                full,
  input  vpp_pkg::vertex_t    vertex,
  input  logic                mid_pop,
  output logic                mid_push,
  output vpp_pkg::mid_item_t  mid_item
);

  localparam int CRED_W = $clog2(vpp_pkg::MID_DEPTH + 1);

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] sum;
    sum = {a[31], a} + {b[31], b};
    if (sum[32] != sum[31]) begin
      sat_add = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_add = sum[31:0];
    end
  endfunction

  logic                     accept;
  logic                     drop;
  logic [CRED_W-1:0]        credit;
  logic [CRED_W-1:0]        credit_next;

  logic                     v1, v2, v3, v4;
  logic signed [31:0]       ox1, oy1, oz1;
  logic signed [63:0]       xp2, yp2, az2;
  logic                     zneg2;
  logic signed [63:0]       xp3, yp3, zp3;
  logic                     zneg3;
  logic signed [63:0]       xp4, yp4, zp4;
  logic                     keep4;
  logic signed [63:0]       near_q;

  assign accept = push && !full;
  assign full   = (credit == CRED_W'(vpp_pkg::MID_DEPTH));
  assign drop   = v4 && !keep4;
  assign near_q = {{16{cfg.near_plane[31]}}, cfg.near_plane, 16'b0};

  // Reserve a queue slot for every vertex in flight; free it on pop or drop.
  always_comb begin
    credit_next = credit + CRED_W'(accept) - CRED_W'(mid_pop) - CRED_W'(drop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      credit <= credit_next;
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    ox1   <= sat_add(vertex.vertex_x, cfg.offset_x);
    oy1   <= sat_add(vertex.vertex_y, cfg.offset_y);
    oz1   <= sat_add(vertex.vertex_z, cfg.offset_z);
    xp2   <= $signed(cfg.scale_xy) * $signed(ox1);
    yp2   <= $signed(cfg.scale_xy) * $signed(oy1);
    az2   <= $signed(cfg.depth_a) * $signed(oz1);
    zneg2 <= oz1[31];
    xp3   <= xp2;
    yp3   <= yp2;
    zp3   <= az2 + {{16{cfg.depth_b[31]}}, cfg.depth_b, 16'b0};
    zneg3 <= zneg2;
    xp4   <= xp3;
    yp4   <= yp3;
    zp4   <= zp3;
    // Keep only points in front of the camera, inside near, with a divisor.
    keep4 <= zneg3 && (zp3 < near_q) && (zp3 != 64'sd0);
  end

  assign mid_push    = v4 && keep4;
  assign mid_item.xp = xp4;
  assign mid_item.yp = yp4;
  assign mid_item.zp = zp4;

endmodule

>>> hdl/vpp_mid_queue.sv
// Short queue between the front end and the divide back end.
module vpp_mid_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  vpp_pkg::mid_item_t  push_item,
  input  logic                pop,
  output logic                empty,
  output vpp_pkg::mid_item_t  pop_item
);

  vpp_pkg::mid_item_t                mem [vpp_pkg::MID_DEPTH];
  logic [vpp_pkg::MID_AW-1:0]        wr_ptr;
  logic [vpp_pkg::MID_AW-1:0]        rd_ptr;
  logic [vpp_pkg::MID_AW:0]          count;

  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (vpp_pkg::MID_AW+1)'(push) - (vpp_pkg::MID_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

>>> hdl/vpp_back.sv
// Back end: screen mapping, pipelined divide, range check and result queue.
module vpp_back (
  input  logic                clk,
  input  logic                rst,
  input  vpp_pkg::cfg_t       cfg,
  input  logic                mid_empty,
  input  vpp_pkg::mid_item_t  mid_item,
  output logic                mid_pop,
  output logic                empty,
  input  logic                pop,
  output vpp_pkg::result_t    result
);

  localparam int NW     = vpp_pkg::NUM_W;
  localparam int PW     = vpp_pkg::PROD_W;
  localparam int QW     = vpp_pkg::QW;
  localparam int CRED_W = vpp_pkg::OUT_AW + 1;
  localparam logic signed [PW-1:0] WIDTH_S  = PW'(vpp_pkg::SCREEN_WIDTH);
  localparam logic signed [PW-1:0] HEIGHT_S = PW'(vpp_pkg::SCREEN_HEIGHT);

  logic                   take;
  logic                   out_pop;
  logic                   drop;
  logic [CRED_W-1:0]      credit;

  logic                   v1, v2, v3, vf;
  logic signed [63:0]     xp1, yp1, zp1;
  logic signed [PW-1:0]   wz1, hz1;
  logic signed [NW-1:0]   sx2, sy2;
  logic [NW-1:0]          dd2, dw2, dh2;
  logic                   zneg2;
  logic signed [NW-1:0]   nx3, ny3;
  logic [NW-1:0]          dd3, dw3, dh3;
  logic                   okf;
  logic [vpp_pkg::ADDR_W-1:0] addr_f;

  logic                   dv_v  [QW];
  logic                   dv_ok [QW];
  logic [NW-1:0]          dv_rx [QW];
  logic [NW-1:0]          dv_ry [QW];
  logic [NW-1:0]          dv_d  [QW];
  logic [QW-1:0]          dv_qx [QW];
  logic [QW-1:0]          dv_qy [QW];

  vpp_pkg::result_t                  mem [vpp_pkg::OUT_DEPTH];
  logic [vpp_pkg::OUT_AW-1:0]        wr_ptr;
  logic [vpp_pkg::OUT_AW-1:0]        rd_ptr;
  logic [vpp_pkg::OUT_AW:0]          count;
  logic                              out_push;

  assign take    = !mid_empty && (credit < CRED_W'(vpp_pkg::OUT_DEPTH));
  assign mid_pop = take;
  assign out_pop = pop && !empty;
  assign drop    = vf && !okf;
  assign out_push = vf && okf;

  // Hold a result slot from the moment a point leaves the middle queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vf <= 1'b0;
    end else begin
      credit <= credit + CRED_W'(take) - CRED_W'(out_pop) - CRED_W'(drop);
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      vf <= dv_v[QW-1];
    end
  end

  // Column is floor((2x' + W z') / (2 z')); same for the row with H.
  always_ff @(posedge clk) begin
    xp1   <= mid_item.xp;
    yp1   <= mid_item.yp;
    zp1   <= mid_item.zp;
    wz1   <= PW'(mid_item.zp) * WIDTH_S;
    hz1   <= PW'(mid_item.zp) * HEIGHT_S;
    sx2   <= (NW'(xp1) <<< 1) + NW'(wz1);
    sy2   <= (NW'(yp1) <<< 1) + NW'(hz1);
    zneg2 <= zp1[63];
    dd2   <= zp1[63] ? (NW'(-NW'(zp1)) << 1) : (NW'(zp1) << 1);
    dw2   <= zp1[63] ? (NW'(-NW'(wz1)) << 1) : (NW'(wz1) << 1);
    dh2   <= zp1[63] ? (NW'(-NW'(hz1)) << 1) : (NW'(hz1) << 1);
    // Flip signs so the divisor is positive.
    nx3   <= zneg2 ? -sx2 : sx2;
    ny3   <= zneg2 ? -sy2 : sy2;
    dd3   <= dd2;
    dw3   <= dw2;
    dh3   <= dh2;
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic              v_in;
    logic              ok_in;
    logic [NW-1:0]     rx_in, ry_in, d_in;
    logic [QW-1:0]     qx_in, qy_in;
    logic [NW-1:0]     trial;
    logic              bx, by;

    if (k == 0) begin : g_first
      assign v_in  = v3;
      assign ok_in = !nx3[NW-1] && !ny3[NW-1] && (NW'(nx3) < dw3) && (NW'(ny3) < dh3);
      assign rx_in = NW'(nx3);
      assign ry_in = NW'(ny3);
      assign d_in  = dd3;
      assign qx_in = '0;
      assign qy_in = '0;
    end else begin : g_next
      assign v_in  = dv_v[k-1];
      assign ok_in = dv_ok[k-1];
      assign rx_in = dv_rx[k-1];
      assign ry_in = dv_ry[k-1];
      assign d_in  = dv_d[k-1];
      assign qx_in = dv_qx[k-1];
      assign qy_in = dv_qy[k-1];
    end

    assign trial = d_in << (QW - 1 - k);
    assign bx    = (rx_in >= trial);
    assign by    = (ry_in >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k] <= 1'b0;
      end else begin
        dv_v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      dv_ok[k] <= ok_in;
      dv_rx[k] <= bx ? rx_in - trial : rx_in;
      dv_ry[k] <= by ? ry_in - trial : ry_in;
      dv_d[k]  <= d_in;
      dv_qx[k] <= (qx_in << 1) | QW'(bx);
      dv_qy[k] <= (qy_in << 1) | QW'(by);
    end
  end

  always_ff @(posedge clk) begin
    okf    <= dv_ok[QW-1];
    addr_f <= vpp_pkg::ADDR_W'(
                vpp_pkg::PIX_W'(dv_qy[QW-1]) * vpp_pkg::PIX_W'(vpp_pkg::SCREEN_WIDTH)
                + vpp_pkg::PIX_W'(dv_qx[QW-1]));
  end

  // Result queue.
  assign empty  = (count == '0);
  assign result = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (out_push) wr_ptr <= wr_ptr + 1'b1;
      if (out_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (vpp_pkg::OUT_AW+1)'(out_push) - (vpp_pkg::OUT_AW+1)'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      mem[wr_ptr].pixel_address <= addr_f;
      mem[wr_ptr].plot_color    <= cfg.pixel_color;
    end
  end

endmodule

>>> hdl/vertex_perspective_plotter.sv
// Vertex perspective plotter: projects Q16.16 model vertices to framebuffer pixels.
// One vertex is accepted per clock while full is low; each result passes
// through 4 front stages, the middle queue, 3 mapping stages, one divide
// stage per column bit (10 at 640x480), one address stage and the result
// queue. The exact divide is a pipeline of restoring stages, so throughput
// stays one vertex per cycle while full is low. Clipped, zero-divisor and
// off-screen vertices produce no result. Registers are written with cfg_we,
// cfg_index, cfg_data and should change only while idle.
module vertex_perspective_plotter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  vpp_pkg::vertex_t                     vertex,
  output logic                                 empty,
  input  logic                                 pop,
  output vpp_pkg::result_t                     result,
  input  logic                                 cfg_we,
  input  logic [vpp_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [vpp_pkg::WORD_W-1:0]           cfg_data
);

  vpp_pkg::cfg_t       cfg;
  logic                mid_push;
  logic                mid_pop;
  logic                mid_empty;
  vpp_pkg::mid_item_t  mid_in;
  vpp_pkg::mid_item_t  mid_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_xy    <= vpp_pkg::ONE_Q16;
      cfg.depth_a     <= vpp_pkg::ONE_Q16;
      cfg.depth_b     <= '0;
      cfg.near_plane  <= vpp_pkg::ONE_Q16;
      cfg.offset_x    <= '0;
      cfg.offset_y    <= '0;
      cfg.offset_z    <= '0;
      cfg.pixel_color <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vpp_pkg::REG_SCALE_XY:    cfg.scale_xy    <= cfg_data;
        vpp_pkg::REG_DEPTH_A:     cfg.depth_a     <= cfg_data;
        vpp_pkg::REG_DEPTH_B:     cfg.depth_b     <= cfg_data;
        vpp_pkg::REG_NEAR_PLANE:  cfg.near_plane  <= cfg_data;
        vpp_pkg::REG_OFFSET_X:    cfg.offset_x    <= cfg_data;
        vpp_pkg::REG_OFFSET_Y:    cfg.offset_y    <= cfg_data;
        vpp_pkg::REG_OFFSET_Z:    cfg.offset_z    <= cfg_data;
        vpp_pkg::REG_PIXEL_COLOR: cfg.pixel_color <= cfg_data;
        default: ;
      endcase
    end
  end

  vpp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .vertex   (vertex),
    .mid_pop  (mid_pop),
    .mid_push (mid_push),
    .mid_item (mid_in)
  );

  vpp_mid_queue u_mid (
    .clk       (clk),
    .rst       (rst),
    .push      (mid_push),
    .push_item (mid_in),
    .pop       (mid_pop),
    .empty     (mid_empty),
    .pop_item  (mid_out)
  );

  vpp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_empty (mid_empty),
    .mid_item  (mid_out),
    .mid_pop   (mid_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
